// ===== hw/rtl/three_state_kalman_guidance_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-state Kalman guidance filter
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_STATE_KALMAN_GUIDANCE_FILTER_TOP_DEFINES_SVH
`define THREE_STATE_KALMAN_GUIDANCE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSKG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tskg port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSKG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tskg port check failed");

`endif

// ===== hw/rtl/tskg_pkg.sv =====
// ----------------------------------------------------------------------------
// tskg_pkg
// Types and constants of the three-state Kalman guidance filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tskg_pkg;

  typedef struct packed {
    logic               restart;
    logic [23:0]        time_to_go;
    logic signed [31:0] measured_los_angle;
  } tskg_in_t;

  typedef struct packed {
    logic signed [47:0] accel_command;
    logic signed [47:0] est_target_accel;
    logic signed [47:0] est_rel_pos;
    logic signed [47:0] est_rel_vel;
    logic [46:0]        accel_variance;
  } tskg_out_t;

  // Configuration register indexes.
  localparam logic [3:0] CFG_CLOSING_SPEED = 4'd0;
  localparam logic [3:0] CFG_NAV_RATIO     = 4'd1;
  localparam logic [3:0] CFG_AUG_MODE      = 4'd2;
  localparam logic [3:0] CFG_PHI           = 4'd3;
  localparam logic [3:0] CFG_LOS_SIGMA     = 4'd4;
  localparam logic [3:0] CFG_INIT_POS_VAR  = 4'd5;
  localparam logic [3:0] CFG_INIT_VEL_VAR  = 4'd6;
  localparam logic [3:0] CFG_INIT_ACC_VAR  = 4'd7;

  // Register reset values.
  localparam logic [29:0] RST_CLOSING_SPEED = 30'd262144000;
  localparam logic [19:0] RST_NAV_RATIO     = 20'd196608;
  localparam logic [46:0] RST_PHI           = 47'd61155312;
  localparam logic [29:0] RST_LOS_SIGMA     = 30'd1073742;
  localparam logic [46:0] RST_INIT_POS_VAR  = 47'd104857600;
  localparam logic [46:0] RST_INIT_VEL_VAR  = 47'd71857799168;
  localparam logic [46:0] RST_INIT_ACC_VAR  = 47'd611553116;

  // Sample-period coefficients with 30 fraction bits.
  localparam logic signed [47:0] K_TS     = 48'sd107374182;
  localparam logic signed [47:0] K_HTS2   = 48'sd5368709;
  localparam logic signed [47:0] K_TS5_20 = 48'sd537;
  localparam logic signed [47:0] K_TS4_8  = 48'sd13422;
  localparam logic signed [47:0] K_TS3_6  = 48'sd178957;
  localparam logic signed [47:0] K_TS3_3  = 48'sd357914;

  localparam logic [47:0] ULIM = 48'h7FFF_FFFF_FFFF;

  // Micro-operations of the sequencer.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_AUG  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIVK = 3'd4;
  localparam logic [2:0] OP_DIVL = 3'd5;

  // Product shift codes.
  localparam logic [1:0] SH_16  = 2'd0;
  localparam logic [1:0] SH_17  = 2'd1;
  localparam logic [1:0] SH_30  = 2'd2;
  localparam logic [1:0] SH_RAW = 2'd3;

  // Operand and destination codes.
  localparam logic [5:0] S_KTS   = 6'd0;
  localparam logic [5:0] S_KHTS2 = 6'd1;
  localparam logic [5:0] S_K520  = 6'd2;
  localparam logic [5:0] S_K48   = 6'd3;
  localparam logic [5:0] S_K36   = 6'd4;
  localparam logic [5:0] S_K33   = 6'd5;
  localparam logic [5:0] S_CS    = 6'd6;
  localparam logic [5:0] S_SIG   = 6'd7;
  localparam logic [5:0] S_PHI   = 6'd8;
  localparam logic [5:0] S_NAV   = 6'd9;
  localparam logic [5:0] S_TGO   = 6'd10;
  localparam logic [5:0] S_ANG   = 6'd11;
  localparam logic [5:0] S_POS   = 6'd12;
  localparam logic [5:0] S_VEL   = 6'd13;
  localparam logic [5:0] S_ACC   = 6'd14;
  localparam logic [5:0] S_LCMD  = 6'd15;
  localparam logic [5:0] S_PP    = 6'd16;
  localparam logic [5:0] S_PV    = 6'd17;
  localparam logic [5:0] S_PA    = 6'd18;
  localparam logic [5:0] S_VV    = 6'd19;
  localparam logic [5:0] S_VA    = 6'd20;
  localparam logic [5:0] S_AA    = 6'd21;
  localparam logic [5:0] S_RTM   = 6'd22;
  localparam logic [5:0] S_SIGN2 = 6'd23;
  localparam logic [5:0] S_A     = 6'd24;
  localparam logic [5:0] S_B     = 6'd25;
  localparam logic [5:0] S_M11   = 6'd26;
  localparam logic [5:0] S_M12   = 6'd27;
  localparam logic [5:0] S_M13   = 6'd28;
  localparam logic [5:0] S_M22   = 6'd29;
  localparam logic [5:0] S_M23   = 6'd30;
  localparam logic [5:0] S_M33   = 6'd31;
  localparam logic [5:0] S_D     = 6'd32;
  localparam logic [5:0] S_K1    = 6'd33;
  localparam logic [5:0] S_K2    = 6'd34;
  localparam logic [5:0] S_K3    = 6'd35;
  localparam logic [5:0] S_DN    = 6'd36;
  localparam logic [5:0] S_PRED  = 6'd37;
  localparam logic [5:0] S_RES   = 6'd38;
  localparam logic [5:0] S_X     = 6'd39;
  localparam logic [5:0] S_Y     = 6'd40;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] src_a;
    logic [5:0] src_b;
    logic [5:0] dst;
    logic [1:0] sh;
  } tskg_uop_t;

  // Saturate a 49-bit sum to the signed 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    logic signed [47:0] r;
    if (x[48] != x[47]) begin
      r = x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

  // Magnitude of a signed 48-bit value as an unsigned 48-bit value.
  function automatic logic [47:0] mag48(input logic signed [47:0] x);
    return x[47] ? (~x + 48'd1) : x;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/three_state_kalman_guidance_filter_top.sv =====
// ----------------------------------------------------------------------------
// three_state_kalman_guidance_filter_top
// One three-state Kalman filter step and proportional navigation command
// per sample, computed by a microcoded sequencer over one shared datapath.
// ----------------------------------------------------------------------------
// Usage:
// A sample is one transfer on the in_ channel (in_valid and in_ready high).
// The block then drops in_ready and runs a fixed micro-program of 77
// operations over one 48 x 16 bit multiplier, one saturating adder and one
// restoring divider that retires one quotient bit per cycle. An add or
// subtract writes back from the issue state; a multiply passes through
// the multiply, rounding and write-back states, and a divide, whether a
// gain divide or the final line-of-sight rate divide, through the divide
// and write-back states. One sample is in flight at a time: the next is
// taken only once the program has finished and its result has been loaded
// into the output register.
// The result sits in an output register on the out_ channel. The next
// sample may be transferred while that result still waits; if the receiver
// stalls so long that the next result is finished, the sequencer holds in
// its final step until the output register is free, and in_ready stays low.
// Configuration writes on the cfg_ channel are always taken (cfg_ready is
// high) and are meant to occur only while no sample is in flight.
// Synchronous reset loads the control and configuration registers with
// their reset values, clears the estimates, loads the diagonal covariances
// with the initial variance reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module three_state_kalman_guidance_filter_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tskg_pkg::tskg_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tskg_pkg::tskg_out_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [3:0]           cfg_index,
  input  wire logic [46:0]          cfg_data
);

  import tskg_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_MRND  = 3'd3;
  localparam logic [2:0] ST_MWB   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DWB   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [6:0] UPC_LAST = 7'd76;

  logic [2:0] state_r, state_nxt;
  logic [6:0] upc_r;
  logic [6:0] cnt_r;
  logic [6:0] div_last_r;

  // Configuration registers.
  logic [29:0] cs_r;
  logic [19:0] nav_r;
  logic        aug_r;
  logic [46:0] phi_r;
  logic [29:0] sig_r;
  logic [46:0] ipv_r, ivv_r, iav_r;

  // Sample registers.
  logic [23:0]        tgo_r;
  logic signed [31:0] ang_r;

  // Filter state.
  logic signed [47:0] pos_r, vel_r, acc_r, lcmd_r;
  logic signed [47:0] cpp_r, cpv_r, cpa_r, cvv_r, cva_r, caa_r;

  // Working registers of the micro-program.
  logic signed [47:0] rtm_r, sign2_r, ta_r, tb_r, m11_r, m12_r, m13_r;
  logic signed [47:0] m22_r, m23_r, m33_r, d_r, k1_r, k2_r, k3_r;
  logic signed [47:0] dn_r, pred_r, res_r, x_r, y_r;

  // Multiplier datapath.
  logic [47:0] ua_r, ub_r;
  logic        neg_r;
  logic [1:0]  sh_r;
  logic [63:0] prod_r;
  logic [95:0] macc_r;
  logic [5:0]  dst_r;

  // Divider datapath.
  logic [47:0] nsh_r, dvs_r, rem_r, q_r;
  logic        over_r, zero_r;

  logic        out_valid_r;
  tskg_out_t   out_data_r;

  logic               in_xfer;
  tskg_uop_t          uop;
  logic signed [47:0] opa, opb;
  logic               wb_en;
  logic signed [47:0] wb_val;
  logic [5:0]         wb_dst;
  logic               out_load;

  function automatic tskg_uop_t mk(input logic [2:0] op, input logic [5:0] a,
                                   input logic [5:0] b, input logic [5:0] d,
                                   input logic [1:0] sh);
    tskg_uop_t u;
    u.op = op;
    u.src_a = a;
    u.src_b = b;
    u.dst = d;
    u.sh = sh;
    return u;
  endfunction

  // Micro-program: measurement noise, covariance propagation, gains,
  // covariance update, estimate update and the guidance command.
  function automatic tskg_uop_t urom(input logic [6:0] pc);
    tskg_uop_t u;
    case (pc)
      7'd0:  u = mk(OP_MUL, S_CS, S_TGO, S_RTM, SH_16);
      7'd1:  u = mk(OP_MUL, S_RTM, S_SIG, S_X, SH_30);
      7'd2:  u = mk(OP_MUL, S_X, S_X, S_SIGN2, SH_16);
      7'd3:  u = mk(OP_MUL, S_KTS, S_VA, S_X, SH_30);
      7'd4:  u = mk(OP_ADD, S_PA, S_X, S_A, SH_30);
      7'd5:  u = mk(OP_MUL, S_KHTS2, S_AA, S_X, SH_30);
      7'd6:  u = mk(OP_ADD, S_A, S_X, S_A, SH_30);
      7'd7:  u = mk(OP_MUL, S_KTS, S_VV, S_X, SH_30);
      7'd8:  u = mk(OP_ADD, S_PV, S_X, S_B, SH_30);
      7'd9:  u = mk(OP_MUL, S_KHTS2, S_VA, S_X, SH_30);
      7'd10: u = mk(OP_ADD, S_B, S_X, S_B, SH_30);
      7'd11: u = mk(OP_MUL, S_KTS, S_PV, S_X, SH_30);
      7'd12: u = mk(OP_ADD, S_PP, S_X, S_M11, SH_30);
      7'd13: u = mk(OP_MUL, S_KHTS2, S_PA, S_X, SH_30);
      7'd14: u = mk(OP_ADD, S_M11, S_X, S_M11, SH_30);
      7'd15: u = mk(OP_MUL, S_KTS, S_B, S_X, SH_30);
      7'd16: u = mk(OP_ADD, S_M11, S_X, S_M11, SH_30);
      7'd17: u = mk(OP_MUL, S_KHTS2, S_A, S_X, SH_30);
      7'd18: u = mk(OP_ADD, S_M11, S_X, S_M11, SH_30);
      7'd19: u = mk(OP_MUL, S_K520, S_PHI, S_X, SH_30);
      7'd20: u = mk(OP_ADD, S_M11, S_X, S_M11, SH_30);
      7'd21: u = mk(OP_MUL, S_KTS, S_A, S_X, SH_30);
      7'd22: u = mk(OP_ADD, S_B, S_X, S_M12, SH_30);
      7'd23: u = mk(OP_MUL, S_K48, S_PHI, S_X, SH_30);
      7'd24: u = mk(OP_ADD, S_M12, S_X, S_M12, SH_30);
      7'd25: u = mk(OP_MUL, S_K36, S_PHI, S_X, SH_30);
      7'd26: u = mk(OP_ADD, S_A, S_X, S_M13, SH_30);
      7'd27: u = mk(OP_MUL, S_KTS, S_VA, S_X, SH_30);
      7'd28: u = mk(OP_ADD, S_VV, S_X, S_M22, SH_30);
      7'd29: u = mk(OP_MUL, S_KTS, S_AA, S_X, SH_30);
      7'd30: u = mk(OP_ADD, S_VA, S_X, S_Y, SH_30);
      7'd31: u = mk(OP_MUL, S_KTS, S_Y, S_X, SH_30);
      7'd32: u = mk(OP_ADD, S_M22, S_X, S_M22, SH_30);
      7'd33: u = mk(OP_MUL, S_K33, S_PHI, S_X, SH_30);
      7'd34: u = mk(OP_ADD, S_M22, S_X, S_M22, SH_30);
      7'd35: u = mk(OP_MUL, S_KHTS2, S_PHI, S_X, SH_30);
      7'd36: u = mk(OP_ADD, S_Y, S_X, S_M23, SH_30);
      7'd37: u = mk(OP_MUL, S_KTS, S_PHI, S_X, SH_30);
      7'd38: u = mk(OP_ADD, S_AA, S_X, S_M33, SH_30);
      7'd39: u = mk(OP_ADD, S_M11, S_SIGN2, S_D, SH_30);
      7'd40: u = mk(OP_DIVK, S_M11, S_D, S_K1, SH_30);
      7'd41: u = mk(OP_DIVK, S_M12, S_D, S_K2, SH_30);
      7'd42: u = mk(OP_DIVK, S_M13, S_D, S_K3, SH_30);
      7'd43: u = mk(OP_MUL, S_K1, S_M11, S_X, SH_30);
      7'd44: u = mk(OP_SUB, S_M11, S_X, S_PP, SH_30);
      7'd45: u = mk(OP_MUL, S_K1, S_M12, S_X, SH_30);
      7'd46: u = mk(OP_SUB, S_M12, S_X, S_PV, SH_30);
      7'd47: u = mk(OP_MUL, S_K1, S_M13, S_X, SH_30);
      7'd48: u = mk(OP_SUB, S_M13, S_X, S_PA, SH_30);
      7'd49: u = mk(OP_MUL, S_K2, S_M12, S_X, SH_30);
      7'd50: u = mk(OP_SUB, S_M22, S_X, S_VV, SH_30);
      7'd51: u = mk(OP_MUL, S_K2, S_M13, S_X, SH_30);
      7'd52: u = mk(OP_SUB, S_M23, S_X, S_VA, SH_30);
      7'd53: u = mk(OP_MUL, S_K3, S_M13, S_X, SH_30);
      7'd54: u = mk(OP_SUB, S_M33, S_X, S_AA, SH_30);
      7'd55: u = mk(OP_SUB, S_ACC, S_LCMD, S_DN, SH_30);
      7'd56: u = mk(OP_MUL, S_KTS, S_VEL, S_X, SH_30);
      7'd57: u = mk(OP_ADD, S_POS, S_X, S_PRED, SH_30);
      7'd58: u = mk(OP_MUL, S_KHTS2, S_DN, S_X, SH_30);
      7'd59: u = mk(OP_ADD, S_PRED, S_X, S_PRED, SH_30);
      7'd60: u = mk(OP_MUL, S_RTM, S_ANG, S_X, SH_30);
      7'd61: u = mk(OP_SUB, S_X, S_PRED, S_RES, SH_30);
      7'd62: u = mk(OP_MUL, S_K1, S_RES, S_X, SH_30);
      7'd63: u = mk(OP_ADD, S_PRED, S_X, S_POS, SH_30);
      7'd64: u = mk(OP_MUL, S_KTS, S_DN, S_X, SH_30);
      7'd65: u = mk(OP_ADD, S_VEL, S_X, S_VEL, SH_30);
      7'd66: u = mk(OP_MUL, S_K2, S_RES, S_X, SH_30);
      7'd67: u = mk(OP_ADD, S_VEL, S_X, S_VEL, SH_30);
      7'd68: u = mk(OP_MUL, S_K3, S_RES, S_X, SH_30);
      7'd69: u = mk(OP_ADD, S_ACC, S_X, S_ACC, SH_30);
      7'd70: u = mk(OP_MUL, S_VEL, S_TGO, S_X, SH_16);
      7'd71: u = mk(OP_ADD, S_POS, S_X, S_Y, SH_30);
      7'd72: u = mk(OP_MUL, S_TGO, S_TGO, S_D, SH_RAW);
      7'd73: u = mk(OP_DIVL, S_Y, S_D, S_X, SH_30);
      7'd74: u = mk(OP_MUL, S_NAV, S_X, S_LCMD, SH_16);
      7'd75: u = mk(OP_MUL, S_NAV, S_ACC, S_X, SH_17);
      7'd76: u = mk(OP_AUG, S_LCMD, S_X, S_LCMD, SH_30);
      default: u = mk(OP_ADD, S_X, S_X, S_X, SH_30);
    endcase
    return u;
  endfunction

  function automatic logic signed [47:0] src_val(input logic [5:0] s);
    logic signed [47:0] v;
    unique case (s)
      S_KTS:   v = K_TS;
      S_KHTS2: v = K_HTS2;
      S_K520:  v = K_TS5_20;
      S_K48:   v = K_TS4_8;
      S_K36:   v = K_TS3_6;
      S_K33:   v = K_TS3_3;
      S_CS:    v = {18'd0, cs_r};
      S_SIG:   v = {18'd0, sig_r};
      S_PHI:   v = {1'b0, phi_r};
      S_NAV:   v = {28'd0, nav_r};
      S_TGO:   v = {24'd0, tgo_r};
      S_ANG:   v = {{16{ang_r[31]}}, ang_r};
      S_POS:   v = pos_r;
      S_VEL:   v = vel_r;
      S_ACC:   v = acc_r;
      S_LCMD:  v = lcmd_r;
      S_PP:    v = cpp_r;
      S_PV:    v = cpv_r;
      S_PA:    v = cpa_r;
      S_VV:    v = cvv_r;
      S_VA:    v = cva_r;
      S_AA:    v = caa_r;
      S_RTM:   v = rtm_r;
      S_SIGN2: v = sign2_r;
      S_A:     v = ta_r;
      S_B:     v = tb_r;
      S_M11:   v = m11_r;
      S_M12:   v = m12_r;
      S_M13:   v = m13_r;
      S_M22:   v = m22_r;
      S_M23:   v = m23_r;
      S_M33:   v = m33_r;
      S_D:     v = d_r;
      S_K1:    v = k1_r;
      S_K2:    v = k2_r;
      S_K3:    v = k3_r;
      S_DN:    v = dn_r;
      S_PRED:  v = pred_r;
      S_RES:   v = res_r;
      S_X:     v = x_r;
      S_Y:     v = y_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign uop = urom(upc_r);
  assign opa = src_val(uop.src_a);
  assign opb = src_val(uop.src_b);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Write-back value for the three kinds of result.
  logic [95:0]        msh;
  logic [47:0]        mres;
  logic [47:0]        dres;
  logic signed [48:0] trial;
  logic               qbit;
  logic [47:0]        q_nxt;

  always_comb begin
    unique case (sh_r)
      SH_16:   msh = macc_r >> 16;
      SH_17:   msh = macc_r >> 17;
      SH_30:   msh = macc_r >> 30;
      default: msh = macc_r;
    endcase
    if (sh_r == SH_RAW) begin
      mres = macc_r[47:0];
    end else begin
      mres = (|msh[95:47]) ? ULIM : msh[47:0];
      if (neg_r) begin
        mres = 48'd0 - mres;
      end
    end

    dres = over_r ? ULIM : q_r;
    if (neg_r) begin
      dres = 48'd0 - dres;
    end
    if (zero_r) begin
      dres = '0;
    end

    trial = {rem_r, nsh_r[47]} - {1'b0, dvs_r};
    qbit  = !trial[48];
    q_nxt = {q_r[46:0], qbit};

    wb_en  = 1'b0;
    wb_val = '0;
    wb_dst = uop.dst;
    unique case (state_r)
      ST_ISSUE: begin
        wb_dst = uop.dst;
        case (uop.op)
          OP_ADD: begin
            wb_en  = 1'b1;
            wb_val = sat48({opa[47], opa} + {opb[47], opb});
          end
          OP_SUB: begin
            wb_en  = 1'b1;
            wb_val = sat48({opa[47], opa} - {opb[47], opb});
          end
          OP_AUG: begin
            wb_en  = 1'b1;
            wb_val = aug_r ? sat48({opa[47], opa} + {opb[47], opb}) : opa;
          end
          default: wb_en = 1'b0;
        endcase
      end
      ST_MWB: begin
        wb_en  = 1'b1;
        wb_dst = dst_r;
        wb_val = mres;
      end
      ST_DWB: begin
        wb_en  = 1'b1;
        wb_dst = dst_r;
        wb_val = dres;
      end
      default: wb_en = 1'b0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (uop.op) inside
          OP_MUL: state_nxt = ST_MUL;
          OP_DIVK, OP_DIVL: state_nxt = ST_DIV;
          default: begin
            if (upc_r == UPC_LAST) begin
              state_nxt = ST_DONE;
            end
          end
        endcase
      end
      ST_MUL:  if (cnt_r == 7'd3) state_nxt = ST_MRND;
      ST_MRND: state_nxt = ST_MWB;
      ST_DIV:  if (cnt_r == div_last_r) state_nxt = ST_DWB;
      ST_MWB, ST_DWB: begin
        state_nxt = (upc_r == UPC_LAST) ? ST_DONE : ST_ISSUE;
      end
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        upc_r <= '0;
      end else if (wb_en && (upc_r != UPC_LAST)) begin
        upc_r <= upc_r + 7'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= RST_CLOSING_SPEED;
      nav_r <= RST_NAV_RATIO;
      aug_r <= 1'b0;
      phi_r <= RST_PHI;
      sig_r <= RST_LOS_SIGMA;
      ipv_r <= RST_INIT_POS_VAR;
      ivv_r <= RST_INIT_VEL_VAR;
      iav_r <= RST_INIT_ACC_VAR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLOSING_SPEED: cs_r  <= cfg_data[29:0];
        CFG_NAV_RATIO:     nav_r <= cfg_data[19:0];
        CFG_AUG_MODE:      aug_r <= cfg_data[0];
        CFG_PHI:           phi_r <= cfg_data;
        CFG_LOS_SIGMA:     sig_r <= cfg_data[29:0];
        CFG_INIT_POS_VAR:  ipv_r <= cfg_data;
        CFG_INIT_VEL_VAR:  ivv_r <= cfg_data;
        CFG_INIT_ACC_VAR:  iav_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter state: reset, restart on a sample transfer with restart set, or write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      vel_r  <= '0;
      acc_r  <= '0;
      lcmd_r <= '0;
      cpp_r  <= {1'b0, RST_INIT_POS_VAR};
      cpv_r  <= '0;
      cpa_r  <= '0;
      cvv_r  <= {1'b0, RST_INIT_VEL_VAR};
      cva_r  <= '0;
      caa_r  <= {1'b0, RST_INIT_ACC_VAR};
    end else if (in_xfer && in_data.restart) begin
      pos_r  <= '0;
      vel_r  <= '0;
      acc_r  <= '0;
      lcmd_r <= '0;
      cpp_r  <= {1'b0, ipv_r};
      cpv_r  <= '0;
      cpa_r  <= '0;
      cvv_r  <= {1'b0, ivv_r};
      cva_r  <= '0;
      caa_r  <= {1'b0, iav_r};
    end else if (wb_en) begin
      case (wb_dst)
        S_POS:  pos_r  <= wb_val;
        S_VEL:  vel_r  <= wb_val;
        S_ACC:  acc_r  <= wb_val;
        S_LCMD: lcmd_r <= wb_val;
        S_PP:   cpp_r  <= wb_val;
        S_PV:   cpv_r  <= wb_val;
        S_PA:   cpa_r  <= wb_val;
        S_VV:   cvv_r  <= wb_val;
        S_VA:   cva_r  <= wb_val;
        S_AA:   caa_r  <= wb_val;
        default: ;
      endcase
    end
  end

  // Working registers and sample capture.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgo_r <= (in_data.time_to_go == 24'd0) ? 24'd1 : in_data.time_to_go;
      ang_r <= in_data.measured_los_angle;
    end
    if (wb_en) begin
      case (wb_dst)
        S_RTM:   rtm_r   <= wb_val;
        S_SIGN2: sign2_r <= wb_val;
        S_A:     ta_r    <= wb_val;
        S_B:     tb_r    <= wb_val;
        S_M11:   m11_r   <= wb_val;
        S_M12:   m12_r   <= wb_val;
        S_M13:   m13_r   <= wb_val;
        S_M22:   m22_r   <= wb_val;
        S_M23:   m23_r   <= wb_val;
        S_M33:   m33_r   <= wb_val;
        S_D:     d_r     <= wb_val;
        S_K1:    k1_r    <= wb_val;
        S_K2:    k2_r    <= wb_val;
        S_K3:    k3_r    <= wb_val;
        S_DN:    dn_r    <= wb_val;
        S_PRED:  pred_r  <= wb_val;
        S_RES:   res_r   <= wb_val;
        S_X:     x_r     <= wb_val;
        S_Y:     y_r     <= wb_val;
        default: ;
      endcase
    end
  end

  // Shared multiplier and divider datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_ISSUE: begin
        dst_r  <= uop.dst;
        cnt_r  <= '0;
        ua_r   <= mag48(opa);
        ub_r   <= mag48(opb);
        sh_r   <= uop.sh;
        neg_r  <= opa[47] ^ opb[47];
        macc_r <= '0;
        nsh_r  <= mag48(opa);
        dvs_r  <= opb;
        rem_r  <= '0;
        q_r    <= '0;
        over_r <= 1'b0;
        if (uop.op == OP_DIVK || uop.op == OP_DIVL) begin
          neg_r <= opa[47];
        end
        zero_r     <= (uop.op == OP_DIVK) && (opb[47] || (opb == 48'sd0));
        div_last_r <= (uop.op == OP_DIVL) ? 7'd79 : 7'd77;
      end
      ST_MUL: begin
        // Multiplier chunks go most significant first; the product of one
        // cycle is accumulated in the next.
        cnt_r <= cnt_r + 7'd1;
        case (cnt_r[1:0])
          2'd0:    prod_r <= ua_r * ub_r[47:32];
          2'd1:    prod_r <= ua_r * ub_r[31:16];
          2'd2:    prod_r <= ua_r * ub_r[15:0];
          default: prod_r <= prod_r;
        endcase
        if (cnt_r != 7'd0) begin
          macc_r <= {macc_r[79:0], 16'd0} + {32'd0, prod_r};
        end
      end
      ST_MRND: begin
        // Round half away from zero on the magnitude.
        unique case (sh_r)
          SH_16:   macc_r <= macc_r + (96'd1 << 15);
          SH_17:   macc_r <= macc_r + (96'd1 << 16);
          SH_30:   macc_r <= macc_r + (96'd1 << 29);
          default: macc_r <= macc_r;
        endcase
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 7'd1;
        nsh_r <= {nsh_r[46:0], 1'b0};
        if (qbit) begin
          rem_r <= trial[47:0];
        end else begin
          rem_r <= {rem_r[46:0], nsh_r[47]};
        end
        q_r    <= q_nxt;
        over_r <= over_r | q_r[47] | q_nxt[47];
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.accel_command    <= lcmd_r;
      out_data_r.est_target_accel <= acc_r;
      out_data_r.est_rel_pos      <= pos_r;
      out_data_r.est_rel_vel      <= vel_r;
      out_data_r.accel_variance   <= caa_r[47] ? 47'd0 : caa_r[46:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tskg_checker.sv =====
// ----------------------------------------------------------------------------
// tskg_checker
// Port-level checks of the guidance filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_state_kalman_guidance_filter_top_defines.svh"

module tskg_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_ready
);

  // A result waits until its transfer.
  `TSKG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A sample transfer starts work: no second sample right after.
  `TSKG_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // A result never appears the cycle after a sample transfer.
  `TSKG_ASSERT_NEXT(a_no_quick_result, in_valid && in_ready, !$rose(out_valid))

  // A new result shows up together with readiness for the next sample.
  `TSKG_ASSERT_SAME(a_ready_with_result, $rose(out_valid), in_ready && cfg_ready)

endmodule

bind three_state_kalman_guidance_filter_top tskg_checker u_tskg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
